### rtl/core/gyro_packet_integrator_top_assert.svh
// assertion macros for the gyro packet integrator
`ifndef GYRO_PACKET_INTEGRATOR_TOP_ASSERT_SVH
`define GYRO_PACKET_INTEGRATOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define GPI_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define GPI_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define GPI_ASSERT_SAME(lbl, clk, rst, ante, cons, msg)
`define GPI_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

### rtl/core/gpi_pkg.sv
// shared constants and types of the gyro packet integrator
package gpi_pkg;
   localparam int SUM_WIDTH    = 64;
   localparam int QUEUE_DEPTH  = 2;
   localparam int SENS_WIDTH   = 10;
   localparam logic [SENS_WIDTH-1:0] SENS_RESET = SENS_WIDTH'(10);
   localparam logic [7:0] KIND_GYRO   = 8'd17;
   localparam logic [7:0] KIND_SENSOR = 8'd4;
   localparam logic [7:0] SENSOR_GYRO = 8'd2;
   localparam logic [5:0] STAMP_BASE_GYRO  = 6'd1;
   localparam logic [5:0] STAMP_BASE_OTHER = 6'd9;
   localparam logic [5:0] RATE_FIRST = 6'd21;
   localparam logic [5:0] RATE_LAST  = 6'd32;
   localparam logic [5:0] POS_MAX    = 6'd63;
   localparam logic [0:0] FUNC_BYTE  = 1'b0;
   localparam logic [0:0] FUNC_READ  = 1'b1;

   typedef struct packed {
      logic             is_read;
      logic [63:0]      stamp;
      logic [2:0][31:0] rate;
   } job_type;
endpackage

### rtl/core/gpi_front.sv
// front end: gathers packet bytes and issues packet and read jobs
module gpi_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [0:0]       in_func,
   input  logic [7:0]       in_byte,
   input  logic             in_last,
   output logic             push,
   output gpi_pkg::job_type push_job,
   input  logic             queue_full
);
   logic [5:0]       pos_ff, pos_in;
   logic [7:0]       kind_ff, kind_in;
   logic [7:0]       sensor_ff, sensor_in;
   logic [63:0]      stamp_ff, stamp_in;
   logic [2:0][31:0] rate_ff, rate_in;
   logic [5:0]       base;
   logic [5:0]       sdiff;
   logic [3:0]       roff;
   logic             xfer;
   logic             used;

   assign in_ready = !queue_full;
   assign xfer     = in_valid && in_ready;

   // field gathering for the current byte
   always_comb begin
      kind_in   = kind_ff;
      sensor_in = sensor_ff;
      stamp_in  = stamp_ff;
      rate_in   = rate_ff;
      pos_in    = pos_ff;
      if (pos_ff == 6'd0) kind_in = in_byte;
      if (pos_ff == 6'd1) sensor_in = in_byte;
      base  = (kind_in == gpi_pkg::KIND_GYRO) ? gpi_pkg::STAMP_BASE_GYRO
                                              : gpi_pkg::STAMP_BASE_OTHER;
      sdiff = pos_ff - base;
      roff  = 4'(pos_ff - gpi_pkg::RATE_FIRST);
      if (pos_ff >= base && pos_ff < base + 6'd8)
         stamp_in[{sdiff[2:0], 3'b000} +: 8] = in_byte;
      if (pos_ff >= gpi_pkg::RATE_FIRST && pos_ff <= gpi_pkg::RATE_LAST)
         rate_in[roff[3:2]][{roff[1:0], 3'b000} +: 8] = in_byte;
      if (in_last) pos_in = 6'd0;
      else if (pos_ff < gpi_pkg::POS_MAX) pos_in = pos_ff + 6'd1;
   end

   assign used = (kind_in == gpi_pkg::KIND_GYRO) ||
                 (kind_in == gpi_pkg::KIND_SENSOR && sensor_in == gpi_pkg::SENSOR_GYRO);

   // job issue: every read, and each complete used packet
   always_comb begin
      push_job.is_read = (in_func == gpi_pkg::FUNC_READ);
      push_job.stamp   = stamp_in;
      push_job.rate    = rate_in;
      push = xfer && ((in_func == gpi_pkg::FUNC_READ) ||
                      (in_last && pos_ff >= gpi_pkg::RATE_LAST && used));
   end

   // gather state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= 6'd0;
         kind_ff   <= 8'd0;
         sensor_ff <= 8'd0;
      end else if (xfer && in_func == gpi_pkg::FUNC_BYTE) begin
         pos_ff    <= pos_in;
         kind_ff   <= kind_in;
         sensor_ff <= sensor_in;
      end
   end

   // gathered payload
   always_ff @(posedge clock) begin
      if (xfer && in_func == gpi_pkg::FUNC_BYTE) begin
         stamp_ff <= stamp_in;
         rate_ff  <= rate_in;
      end
   end
endmodule

### rtl/core/gpi_queue.sv
// short job queue between front and back
module gpi_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  gpi_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output gpi_pkg::job_type head
);
   localparam int PW = $clog2(gpi_pkg::QUEUE_DEPTH);
   localparam int CW = $clog2(gpi_pkg::QUEUE_DEPTH + 1);

   gpi_pkg::job_type        slot_ff [gpi_pkg::QUEUE_DEPTH];
   logic [PW-1:0]           wr_ff, rd_ff;
   logic [CW-1:0]           count_ff;

   assign full      = (count_ff == CW'(gpi_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ff];

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) wr_ff <= (wr_ff == PW'(gpi_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         if (pop)  rd_ff <= (rd_ff == PW'(gpi_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         if (push && !pop) count_ff <= count_ff + 1'b1;
         else if (pop && !push) count_ff <= count_ff - 1'b1;
      end
   end

   // job storage
   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_job;
   end
endmodule

### rtl/core/gpi_back.sv
// back end: time difference, rate conversion, product and saturating sums
`include "gyro_packet_integrator_top_assert.svh"
module gpi_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [gpi_pkg::SENS_WIDTH-1:0]  sens,
   input  logic                            job_valid,
   input  gpi_pkg::job_type                job,
   output logic                            pop,
   output logic                            out_valid,
   input  logic                            out_ready,
   output logic [191:0]                    out_data,
   output logic                            out_sat
);
   localparam int W = gpi_pkg::SUM_WIDTH;
   localparam logic [63:0] MAX_MAG = (64'd1 << (W - 1)) - 64'd1;
   localparam logic [63:0] MIN_MAG = 64'd1 << (W - 1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_CONV, ST_MUL, ST_MAG, ST_ACC
   } state_type;

   state_type        state_ff;
   logic [1:0]       axis_ff;
   logic [1:0]       step_ff;
   logic [63:0]      prev_ff;
   logic [63:0]      diff_ff;
   logic [2:0][31:0] rate_ff;
   logic [63:0]      q_ff;
   logic             huge_ff, nan_ff;
   logic [127:0]     acc_ff;
   logic [W-1:0]     prod_ff;
   logic [W-1:0]     sum_ff [3];
   logic             clip_ff;
   logic             out_valid_ff;
   logic [191:0]     out_data_ff;
   logic             out_sat_ff;

   logic [31:0]      bits;
   logic [7:0]       e;
   logic [22:0]      frac;
   logic [23:0]      m;
   logic signed [9:0] ex;
   logic [9:0]       nsh;
   logic [33:0]      p;
   logic [127:0]     wide;
   logic [63:0]      q_in;
   logic             huge_in, nan_in;
   logic [31:0]      qa, da;
   logic [63:0]      pp;
   logic [127:0]     acc_in;
   logic [63:0]      lim;
   logic [W-1:0]     mag;
   logic             mag_clip;
   logic [W:0]       wsum;
   logic [W-1:0]     sum_in;
   logic             sum_clip;
   logic             out_free;

   assign out_free  = !out_valid_ff || out_ready;
   assign pop       = (state_ff == ST_IDLE) && job_valid && (!job.is_read || out_free);
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;
   assign out_sat   = out_sat_ff;

   // rate float times sensitivity to truncated fixed magnitude
   always_comb begin
      bits    = rate_ff[axis_ff];
      e       = bits[30:23];
      frac    = bits[22:0];
      m       = (e == 8'd0) ? {1'b0, frac} : {1'b1, frac};
      ex      = (e == 8'd0) ? -10'sd149 : $signed({2'b00, e}) - 10'sd150;
      nsh     = 10'(-ex);
      p       = 34'(m) * 34'(sens);
      wide    = 128'(p) << ex[5:0];
      q_in    = 64'd0;
      huge_in = 1'b0;
      nan_in  = 1'b0;
      if (e == 8'hFF) begin
         nan_in  = (frac != 23'd0);
         huge_in = (frac == 23'd0) && (sens != '0);
      end else if (p == 34'd0) begin
         q_in = 64'd0;
      end else if (ex >= 0) begin
         if (ex > 10'sd63) huge_in = 1'b1;
         else begin
            huge_in = |wide[127:63];
            q_in    = wide[63:0];
         end
      end else if (nsh < 10'd64) begin
         q_in = 64'(p) >> nsh[5:0];
      end
   end

   // one 32x32 partial product per step
   always_comb begin
      qa     = step_ff[0] ? q_ff[63:32] : q_ff[31:0];
      da     = step_ff[1] ? diff_ff[63:32] : diff_ff[31:0];
      pp     = 64'(qa) * 64'(da);
      acc_in = acc_ff + (128'(pp) << {({1'b0, step_ff[0]} + {1'b0, step_ff[1]}), 5'b00000});
   end

   // product magnitude with clip, then signed product
   always_comb begin
      lim      = bits[31] ? MIN_MAG : MAX_MAG;
      mag_clip = 1'b0;
      if (nan_ff || diff_ff == 64'd0 || (!huge_ff && q_ff == 64'd0)) mag = '0;
      else if (huge_ff || acc_ff > 128'(lim)) begin
         mag      = W'(lim);
         mag_clip = 1'b1;
      end else mag = W'(acc_ff[63:0]);
   end

   // saturating accumulate
   always_comb begin
      wsum     = {sum_ff[axis_ff][W-1], sum_ff[axis_ff]} + {prod_ff[W-1], prod_ff};
      sum_clip = (wsum[W] != wsum[W-1]);
      if (!sum_clip) sum_in = wsum[W-1:0];
      else if (wsum[W]) sum_in = W'(MIN_MAG);
      else sum_in = W'(MAX_MAG);
   end

   // sequencer, sums and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         axis_ff      <= 2'd0;
         step_ff      <= 2'd0;
         prev_ff      <= 64'd0;
         clip_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) sum_ff[i] <= '0;
      end else begin
         if (out_valid_ff && out_ready && !(pop && job.is_read)) out_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (pop && job.is_read) begin
                  out_valid_ff <= 1'b1;
                  out_data_ff  <= {64'($signed(sum_ff[2])), 64'($signed(sum_ff[1])),
                                   64'($signed(sum_ff[0]))};
                  out_sat_ff   <= clip_ff;
                  clip_ff      <= 1'b0;
                  for (int i = 0; i < 3; i++) sum_ff[i] <= '0;
               end else if (pop) begin
                  prev_ff <= job.stamp;
                  diff_ff <= job.stamp - prev_ff;
                  rate_ff <= job.rate;
                  axis_ff <= 2'd0;
                  if (prev_ff != 64'd0) state_ff <= ST_CONV;
               end
            end
            ST_CONV: begin
               q_ff     <= q_in;
               huge_ff  <= huge_in;
               nan_ff   <= nan_in;
               acc_ff   <= 128'd0;
               step_ff  <= 2'd0;
               state_ff <= ST_MUL;
            end
            ST_MUL: begin
               acc_ff  <= acc_in;
               step_ff <= step_ff + 2'd1;
               if (step_ff == 2'd3) state_ff <= ST_MAG;
            end
            ST_MAG: begin
               prod_ff  <= bits[31] ? W'(-mag) : mag;
               if (mag_clip) clip_ff <= 1'b1;
               state_ff <= ST_ACC;
            end
            ST_ACC: begin
               sum_ff[axis_ff] <= sum_in;
               if (sum_clip) clip_ff <= 1'b1;
               if (axis_ff == 2'd2) state_ff <= ST_IDLE;
               else begin
                  axis_ff  <= axis_ff + 2'd1;
                  state_ff <= ST_CONV;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   `GPI_ASSERT_SAME(a_pop_idle, clock, reset, pop, state_ff == ST_IDLE, "job taken while busy")
   `GPI_ASSERT_SAME(a_axis_range, clock, reset, state_ff != ST_IDLE, axis_ff != 2'd3, "bad axis")
   `GPI_ASSERT_NEXT(a_read_clears, clock, reset, pop && job.is_read, !clip_ff && out_valid_ff, "read did not clear")
endmodule

### rtl/core/gyro_packet_integrator_top.sv
// top level of the gyro packet integrator
//  channel | dir | payload
//  req_    | in  | tdata: data_byte[7:0]; tuser: func; tlast: last
//  rsp_    | out | tdata: angle_x, angle_y, angle_z (64 bit each); tuser: saturated
//  csr_    | in  | csr_data: sensitivity[9:0]
// the front end takes one packet byte per cycle while the job queue is not full; the back end
// takes a job while idle and on a used packet works through each axis in turn (conversion,
// four 32x32 multiplier passes, clip, accumulate) on one shared multiplier
// a read is taken once the result register is free
// synchronous reset clears all control state and the sums; no clearing pass
// a two-entry job queue lets bytes keep flowing while the back end works or rsp_ stalls
module gyro_packet_integrator_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // data_byte[7:0]
   input  logic [0:0]   req_tuser,   // func[0]
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [191:0] rsp_tdata,   // angle_x[63:0], angle_y[127:64], angle_z[191:128]
   output logic [0:0]   rsp_tuser,   // saturated[0]
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [9:0]   csr_data
);
   logic [gpi_pkg::SENS_WIDTH-1:0] sens_ff;
   logic                           push, full, pop, not_empty, sat;
   gpi_pkg::job_type               push_job, head;

   // sensitivity register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) sens_ff <= gpi_pkg::SENS_RESET;
      else if (csr_valid) sens_ff <= csr_data;
   end

   gpi_front u_front (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready), .in_func(req_tuser),
      .in_byte(req_tdata), .in_last(req_tlast),
      .push, .push_job, .queue_full(full)
   );

   gpi_queue u_queue (
      .clock, .reset, .push, .push_job, .full, .pop, .not_empty, .head
   );

   gpi_back u_back (
      .clock, .reset, .sens(sens_ff), .job_valid(not_empty), .job(head), .pop,
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_data(rsp_tdata), .out_sat(sat)
   );

   assign rsp_tuser = sat;
endmodule

### tb/sv/tb_gyro_packet_integrator_top.sv
// testbench for the gyro packet integrator: packet bytes and reads against a rate integrator
`timescale 1ns / 100ps

module tb_gyro_packet_integrator_top;

   typedef struct {
      logic [63:0] x;
      logic [63:0] y;
      logic [63:0] z;
      logic        sat;
   } angle_read_type;

   // one directed row: a packet, or a read where pkt_len is zero
   typedef struct {
      logic [7:0]       kind;
      logic [7:0]       sensor;
      logic [63:0]      stamp;
      logic [2:0][31:0] rates;
      int               pkt_len;
      int               read_at;
      bit               has_exp;
      angle_read_type   exp;
   } dir_row_type;

   localparam logic [31:0] F_POS_INF = 32'h7F80_0000;
   localparam logic [31:0] F_NEG_INF = 32'hFF80_0000;
   localparam logic [31:0] F_NAN     = 32'h7FC0_0000;
   localparam logic [31:0] F_MAX     = 32'h7F7F_FFFF;
   localparam logic [31:0] F_NEG_MAX = 32'hFF7F_FFFF;
   localparam logic [31:0] F_DENORM  = 32'h0000_0001;
   localparam logic [31:0] F_ONE     = 32'h3F80_0000;
   localparam int          ITEM_GOAL = 1100;
   localparam int          READ_GOAL = 40;
   localparam int          NUM_PHASES = 6;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [7:0]   req_tdata;
   logic [0:0]   req_tuser;
   logic         req_tlast;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [191:0] rsp_tdata;
   logic [0:0]   rsp_tuser;
   logic         csr_valid;
   logic         csr_ready;
   logic [9:0]   csr_data;

   // integrator state mirrored on the testbench side
   logic [9:0]        sens_m;
   int unsigned       pos_m;
   logic [7:0]        kind_m;
   logic [7:0]        sensor_m;
   logic [63:0]       stamp_m;
   logic [63:0]       prev_stamp_m;
   logic [31:0]       rate_m [3];
   logic [63:0]       sum_m [3];
   bit                clip_m;

   angle_read_type    angle_q[$];
   int                fail_count;
   int                n_items;
   int                n_reads;
   bit                quiet;
   bit                hold_req;
   dir_row_type       dir_rows[$];

   gyro_packet_integrator_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // clock
   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // reset
   initial begin
      reset = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   // run limit
   initial begin
      #5000000;
      $display("Test completed with failures");
      $finish;
   end

   // magnitude of trunc(|rate| * sens); huge when it reaches 2^63
   function automatic logic [63:0] rate_steps(input logic [31:0] bits, input logic [9:0] s,
                                              output bit huge, output bit nan);
      logic [7:0]  e;
      logic [22:0] fr;
      logic [63:0] m;
      logic [63:0] p;
      int          ex;
      e = bits[30:23];
      fr = bits[22:0];
      huge = 1'b0;
      nan = 1'b0;
      if (e == 8'hFF) begin
         if (fr != 0) nan = 1'b1;
         else if (s != 0) huge = 1'b1;
         return 64'd0;
      end
      if (e == 8'd0) begin
         m = {41'd0, fr};
         ex = -149;
      end else begin
         m = {40'd0, 1'b1, fr};
         ex = int'(e) - 150;
      end
      p = m * {54'd0, s};
      if (p == 0) return 64'd0;
      if (ex >= 0) begin
         if (ex > 63 || (p >> (63 - ex)) != 0) begin
            huge = 1'b1;
            return 64'd0;
         end
         return p << ex;
      end
      if (-ex >= 64) return 64'd0;
      return p >> (-ex);
   endfunction

   // add one axis product into its sum, clipping both
   function automatic void add_axis(input int axis, input logic [63:0] diff);
      bit                 huge;
      bit                 nan;
      bit                 neg;
      logic [63:0]        q;
      logic [63:0]        lim;
      logic [63:0]        mag;
      logic [63:0]        prod;
      logic [64:0]        t;
      q = rate_steps(rate_m[axis], sens_m, huge, nan);
      neg = rate_m[axis][31];
      lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      if (nan || diff == 0 || (!huge && q == 0)) begin
         mag = 64'd0;
      end else if (huge || q > lim || diff > lim / q) begin
         mag = lim;
         clip_m = 1'b1;
      end else begin
         mag = q * diff;
      end
      prod = neg ? -mag : mag;
      t = {sum_m[axis][63], sum_m[axis]} + {prod[63], prod};
      if (t[64] != t[63]) begin
         sum_m[axis] = t[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
         clip_m = 1'b1;
      end else begin
         sum_m[axis] = t[63:0];
      end
   endfunction

   // end of a long enough packet: ignore it if unused, else prime or integrate
   function automatic void close_packet();
      logic [63:0] diff;
      if (!(kind_m == gpi_pkg::KIND_GYRO ||
            (kind_m == gpi_pkg::KIND_SENSOR && sensor_m == gpi_pkg::SENSOR_GYRO))) return;
      if (prev_stamp_m == 0) begin
         prev_stamp_m = stamp_m;
         return;
      end
      diff = stamp_m - prev_stamp_m;
      prev_stamp_m = stamp_m;
      for (int i = 0; i < 3; i++) add_axis(i, diff);
   endfunction

   // one accepted transfer; returns 1 with the angles a read produces
   function automatic bit integrate_item(input logic [0:0] f, input logic [7:0] b,
                                         input logic l, output angle_read_type r);
      int unsigned p;
      int unsigned base;
      int unsigned k;
      r = '{default: '0};
      if (f == gpi_pkg::FUNC_READ) begin
         r = '{sum_m[0], sum_m[1], sum_m[2], clip_m};
         for (int i = 0; i < 3; i++) sum_m[i] = 64'd0;
         clip_m = 1'b0;
         return 1'b1;
      end
      p = pos_m;
      if (p == 0) kind_m = b;
      if (p == 1) sensor_m = b;
      base = (kind_m == gpi_pkg::KIND_GYRO) ? gpi_pkg::STAMP_BASE_GYRO
                                            : gpi_pkg::STAMP_BASE_OTHER;
      if (p >= base && p < base + 8) stamp_m[8 * (p - base) +: 8] = b;
      if (p >= gpi_pkg::RATE_FIRST && p <= gpi_pkg::RATE_LAST) begin
         k = p - gpi_pkg::RATE_FIRST;
         rate_m[k / 4][8 * (k % 4) +: 8] = b;
      end
      if (l) begin
         if (p >= gpi_pkg::RATE_LAST) close_packet();
         pos_m = 0;
      end else if (p < gpi_pkg::POS_MAX) begin
         pos_m = p + 1;
      end
      return 1'b0;
   endfunction

   // offer one transfer, sometimes with a random gap first, and predict on acceptance
   task automatic push_item(input logic [0:0] f, input logic [7:0] b, input logic l,
                            input bit has_exp, input angle_read_type exp);
      angle_read_type r;
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tuser <= f;
      req_tlast <= l;
      do @(posedge clock); while (!req_tready);
      n_items++;
      if (integrate_item(f, b, l, r)) begin
         n_reads++;
         angle_q.push_back(has_exp ? exp : r);
      end
   endtask

   // send a whole packet, optionally with a read slipped in before byte read_at
   task automatic send_packet(input logic [7:0] kind, input logic [7:0] sensor,
                              input logic [63:0] stamp, input logic [2:0][31:0] rates,
                              input int pkt_len, input int read_at);
      logic [7:0] b;
      int         base;
      angle_read_type none;
      none = '{default: '0};
      base = (kind == gpi_pkg::KIND_GYRO) ? gpi_pkg::STAMP_BASE_GYRO
                                          : gpi_pkg::STAMP_BASE_OTHER;
      for (int i = 0; i < pkt_len; i++) begin
         b = 8'($urandom);
         if (i == 0) b = kind;
         if (i == 1) b = sensor;
         if (i >= base && i < base + 8) b = stamp[8 * (i - base) +: 8];
         if (i >= gpi_pkg::RATE_FIRST && i <= gpi_pkg::RATE_LAST)
            b = rates[(i - gpi_pkg::RATE_FIRST) / 4][8 * ((i - gpi_pkg::RATE_FIRST) % 4) +: 8];
         if (i == read_at)
            push_item(gpi_pkg::FUNC_READ, 8'($urandom), 1'($urandom), 1'b0, none);
         push_item(gpi_pkg::FUNC_BYTE, b, i == pkt_len - 1, 1'b0, none);
      end
   endtask

   // configuration write, only once the block has gone idle
   task automatic set_sensitivity(input logic [9:0] v);
      req_tvalid <= 1'b0;
      while (angle_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sens_m = v;
   endtask

   function automatic logic [31:0] pick_rate();
      case ($urandom_range(0, 11))
         0: return $urandom;
         1: return F_NAN;
         2: return $urandom_range(0, 1) ? F_POS_INF : F_NEG_INF;
         3: return {1'($urandom), 8'd0, 23'($urandom)};
         4: return {1'($urandom), 8'($urandom_range(180, 254)), 23'($urandom)};
         default: return {1'($urandom), 8'($urandom_range(100, 150)), 23'($urandom)};
      endcase
   endfunction

   function automatic logic [63:0] pick_stamp();
      case ($urandom_range(0, 11))
         0: return 64'd0;
         1: return {32'($urandom), 32'($urandom)};
         2: return prev_stamp_m;
         3: return prev_stamp_m - 64'($urandom_range(1, 50));
         default: return prev_stamp_m + 64'($urandom_range(1, 3000));
      endcase
   endfunction

   function automatic int pick_len();
      case ($urandom_range(0, 9))
         0: return $urandom_range(1, 32);
         1: return $urandom_range(41, 63);
         2: return $urandom_range(64, 75);
         default: return $urandom_range(33, 40);
      endcase
   endfunction

   task automatic random_packet();
      logic [7:0]       kind;
      logic [7:0]       sensor;
      logic [2:0][31:0] rates;
      int               pkt_len;
      angle_read_type   none;
      none = '{default: '0};
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: begin kind = gpi_pkg::KIND_GYRO; sensor = 8'($urandom); end
         6, 7: begin kind = gpi_pkg::KIND_SENSOR; sensor = gpi_pkg::SENSOR_GYRO; end
         8: begin kind = gpi_pkg::KIND_SENSOR; sensor = 8'($urandom); end
         default: begin kind = 8'($urandom); sensor = 8'($urandom); end
      endcase
      for (int i = 0; i < 3; i++) rates[i] = pick_rate();
      pkt_len = pick_len();
      send_packet(kind, sensor, pick_stamp(), rates, pkt_len,
                  ($urandom_range(0, 5) == 0) ? $urandom_range(0, pkt_len - 1) : -1);
      if ($urandom_range(0, 2) != 0)
         push_item(gpi_pkg::FUNC_READ, 8'($urandom), 1'($urandom), 1'b0, none);
   endtask

   function automatic dir_row_type pkt_row(input logic [7:0] kind, input logic [7:0] sensor,
                                           input logic [63:0] stamp, input logic [31:0] r0,
                                           input logic [31:0] r1, input logic [31:0] r2,
                                           input int pkt_len, input int read_at);
      dir_row_type row;
      row.kind = kind;
      row.sensor = sensor;
      row.stamp = stamp;
      row.rates = {r2, r1, r0};
      row.pkt_len = pkt_len;
      row.read_at = read_at;
      row.has_exp = 1'b0;
      row.exp = '{default: '0};
      return row;
   endfunction

   function automatic dir_row_type read_row(input bit has_exp, input angle_read_type exp);
      dir_row_type row;
      row = pkt_row(8'd0, 8'd0, 64'd0, 32'd0, 32'd0, 32'd0, 0, -1);
      row.has_exp = has_exp;
      row.exp = exp;
      return row;
   endfunction

   // result checking
   always @(posedge clock) begin
      angle_read_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (angle_q.size() == 0) begin
            $error("result transfer with no read pending");
            fail_count++;
         end else begin
            e = angle_q.pop_front();
            if (rsp_tdata[63:0] !== e.x) begin
               $error("angle_x expected %0h actual %0h", e.x, rsp_tdata[63:0]);
               fail_count++;
            end
            if (rsp_tdata[127:64] !== e.y) begin
               $error("angle_y expected %0h actual %0h", e.y, rsp_tdata[127:64]);
               fail_count++;
            end
            if (rsp_tdata[191:128] !== e.z) begin
               $error("angle_z expected %0h actual %0h", e.z, rsp_tdata[191:128]);
               fail_count++;
            end
            if (rsp_tuser[0] !== e.sat) begin
               $error("saturated expected %0b actual %0b", e.sat, rsp_tuser[0]);
               fail_count++;
            end
         end
      end
   end

   // result side backpressure, with one long hold-off
   initial begin
      bit held;
      held = 1'b0;
      rsp_tready = 1'b0;
      wait (!reset);
      forever begin
         @(posedge clock);
         if (hold_req && !held) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // stimulus
   initial begin
      logic [9:0]     sens_plan [NUM_PHASES];
      angle_read_type zero_read;
      dir_row_type    row;
      int             dir_items;
      req_tvalid = 1'b0;
      req_tdata = 8'd0;
      req_tuser = gpi_pkg::FUNC_BYTE;
      req_tlast = 1'b0;
      csr_valid = 1'b0;
      csr_data = 10'd0;
      fail_count = 0;
      n_items = 0;
      n_reads = 0;
      quiet = 1'b0;
      hold_req = 1'b0;
      sens_m = gpi_pkg::SENS_RESET;
      pos_m = 0;
      kind_m = 8'd0;
      sensor_m = 8'd0;
      stamp_m = 64'd0;
      prev_stamp_m = 64'd0;
      clip_m = 1'b0;
      for (int i = 0; i < 3; i++) begin
         rate_m[i] = 32'd0;
         sum_m[i] = 64'd0;
      end
      zero_read = '{64'd0, 64'd0, 64'd0, 1'b0};

      // directed rows at the reset sensitivity
      dir_rows.push_back(read_row(1'b1, zero_read));
      dir_rows.push_back(pkt_row(gpi_pkg::KIND_GYRO, 8'd0, 64'd1000, 32'h3FC0_0000,
                                 32'hC010_0000, 32'h3DCC_CCCD, 33, -1));
      dir_rows.push_back(pkt_row(gpi_pkg::KIND_GYRO, 8'd0, 64'd1100, 32'h3FC0_0000,
                                 32'hC010_0000, 32'h3DCC_CCCD, 33, -1));
      dir_rows.push_back(read_row(1'b0, zero_read));
      dir_rows.push_back(pkt_row(gpi_pkg::KIND_SENSOR, gpi_pkg::SENSOR_GYRO, 64'd1300, F_ONE,
                                 F_DENORM, 32'hBF80_0000, 40, -1));
      // unused sensor, short packet, long packet
      dir_rows.push_back(pkt_row(gpi_pkg::KIND_SENSOR, 8'd3, 64'd5, F_ONE, F_ONE, F_ONE,
                                 33, -1));
      dir_rows.push_back(pkt_row(gpi_pkg::KIND_GYRO, 8'd0, 64'd9999, F_ONE, F_ONE, F_ONE,
                                 32, -1));
      dir_rows.push_back(pkt_row(gpi_pkg::KIND_GYRO, 8'd0, 64'd1400, F_ONE, F_ONE, F_ONE,
                                 70, -1));
      // zero stamp, then prime again, then zero difference with infinite rates
      dir_rows.push_back(pkt_row(gpi_pkg::KIND_GYRO, 8'd0, 64'd0, F_ONE, F_ONE, F_ONE, 33, -1));
      dir_rows.push_back(pkt_row(gpi_pkg::KIND_GYRO, 8'd0, 64'd50, F_ONE, F_ONE, F_ONE, 33, -1));
      dir_rows.push_back(pkt_row(gpi_pkg::KIND_GYRO, 8'd0, 64'd50, F_POS_INF, F_NEG_INF, F_NAN,
                                 33, -1));
      dir_rows.push_back(read_row(1'b0, zero_read));
      // nan, infinities: product clip
      dir_rows.push_back(pkt_row(gpi_pkg::KIND_GYRO, 8'd0, 64'd60, F_NAN, F_POS_INF, F_NEG_INF,
                                 33, -1));
      dir_rows.push_back(read_row(1'b0, zero_read));
      // largest floats twice: sum clip
      dir_rows.push_back(pkt_row(gpi_pkg::KIND_GYRO, 8'd0, 64'd70, F_MAX, F_NEG_MAX, F_DENORM,
                                 33, -1));
      dir_rows.push_back(pkt_row(gpi_pkg::KIND_GYRO, 8'd0, 64'd80, F_MAX, F_NEG_MAX, F_DENORM,
                                 33, -1));
      dir_rows.push_back(read_row(1'b0, zero_read));
      // stamp going backward wraps to a huge difference
      dir_rows.push_back(pkt_row(gpi_pkg::KIND_GYRO, 8'd0, 64'd5, F_ONE, 32'hBF80_0000,
                                 32'h3F00_0000, 33, -1));
      dir_rows.push_back(read_row(1'b0, zero_read));
      // read slipped into the middle of a packet
      dir_rows.push_back(pkt_row(gpi_pkg::KIND_SENSOR, gpi_pkg::SENSOR_GYRO,
                                 64'hFFFF_FFFF_FFFF_FFFF, 32'h4120_0000, 32'hC2C8_0000, F_ONE,
                                 36, 10));
      dir_rows.push_back(read_row(1'b0, zero_read));

      wait (!reset);
      @(posedge clock);
      foreach (dir_rows[i]) begin
         row = dir_rows[i];
         if (row.pkt_len == 0)
            push_item(gpi_pkg::FUNC_READ, 8'hFF, 1'b1, row.has_exp, row.exp);
         else
            send_packet(row.kind, row.sensor, row.stamp, row.rates, row.pkt_len, row.read_at);
      end
      dir_items = n_items;

      // random phases over several sensitivities
      sens_plan[0] = 10'd1;
      sens_plan[1] = 10'd1000;
      sens_plan[2] = 10'd1023;
      sens_plan[3] = 10'd0;
      sens_plan[4] = 10'($urandom_range(2, 999));
      sens_plan[5] = gpi_pkg::SENS_RESET;
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         set_sensitivity(sens_plan[ph]);
         if (ph == 0) hold_req = 1'b1;
         if (ph == NUM_PHASES - 1) begin
            quiet = 1'b1;
            while (n_items < ITEM_GOAL || n_reads < READ_GOAL) random_packet();
         end else begin
            while (n_items < dir_items + (ph + 1) * (ITEM_GOAL - dir_items) / NUM_PHASES)
               random_packet();
         end
      end

      req_tvalid <= 1'b0;
      while (angle_q.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
